/* hdl/svalloc_pkg.sv */
// types, constants and codes shared by the voice allocator modules
`default_nettype none
package svalloc_pkg;

   localparam int VOICES    = 16;
   localparam int SOUND_IDS = 256;
   localparam int VIDX_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int MASK_N    = (VOICES < 16) ? VOICES : 16;

   typedef enum logic [2:0] {
      OP_PLAY        = 3'd0,
      OP_STOP_HANDLE = 3'd1,
      OP_STOP_ID     = 3'd2,
      OP_STOP_ALL    = 3'd3,
      OP_ADVANCE     = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  sound_id;
      logic [31:0] sound_length;
      logic [31:0] voice_handle;
      logic [31:0] advance_bytes;
   } req_type;

   typedef struct packed {
      logic [31:0] new_handle;
      logic        stop_hit;
      logic [15:0] active_mask;
   } rsp_type;

endpackage
`default_nettype wire

/* hdl/sound_voice_allocator_top.sv */
// voice allocator: voice table, scan sequencer and response register
//
// A request (req) is taken at a rising edge where start is high and busy is
// low. Opcodes: play, stop by handle, stop by sound id, stop all, advance.
// The sequencer visits one voice per cycle through a single shared
// saturating add/compare unit; every scanning request walks all VOICES
// voices in the scan state, then goes through the commit state (play
// only) and then the response state. Unknown opcodes and plays with an
// out-of-range sound id skip the scan and answer in the cycle right after
// acceptance.
// The response (rsp) is shown for exactly one cycle with rsp_valid high;
// a new request can be taken in that same cycle, since busy is low there.
// The receiver cannot stall, so nothing is held back.
// Reset (synchronous, active high) clears all voices, all stored handles,
// sounds, positions and lengths, and the handle counter; no clearing pass
// is needed.
`default_nettype none
module sound_voice_allocator_top (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire svalloc_pkg::req_type req,
   output logic                      rsp_valid,
   output svalloc_pkg::rsp_type      rsp
);

   svalloc_pkg::state_type state_ff, state_in;
   svalloc_pkg::req_type   req_ff;

   logic [svalloc_pkg::VIDX_W-1:0] idx_ff, idx_in;
   logic [svalloc_pkg::VIDX_W-1:0] pick_ff, pick_in;
   logic [31:0]                    best_ff, best_in;
   logic                           have_ff, have_in;
   logic                           free_ff, free_in;
   logic                           done_ff, done_in;
   logic                           was_ff, was_in;
   logic [31:0]                    handle_ff, handle_in;
   logic [31:0]                    counter_ff, counter_in;
   logic [svalloc_pkg::VOICES-1:0] active_ff, active_in;

   logic [31:0] vhandle_ff [svalloc_pkg::VOICES];
   logic [7:0]  vsound_ff  [svalloc_pkg::VOICES];
   logic [31:0] vpos_ff    [svalloc_pkg::VOICES];
   logic [31:0] vlen_ff    [svalloc_pkg::VOICES];

   logic        accept;
   logic        last;
   logic        sid_ok;
   logic        commit_we;
   logic        pos_we;
   logic [31:0] ua, ub, uc, usum;
   logic        ult, ueq;

   svalloc_unit u_unit (
      .a   (ua),
      .b   (ub),
      .c   (uc),
      .sum (usum),
      .lt  (ult),
      .eq  (ueq)
   );

   assign busy   = (state_ff == svalloc_pkg::ST_SCAN) || (state_ff == svalloc_pkg::ST_COMMIT);
   assign accept = start && !busy;
   assign last   = idx_ff == svalloc_pkg::VIDX_W'(svalloc_pkg::VOICES - 1);
   assign sid_ok = 32'(req.sound_id) < 32'(svalloc_pkg::SOUND_IDS);

   // shared unit operand selection
   always_comb begin
      ua = 32'd0;
      ub = 32'd0;
      uc = 32'd0;
      case (req_ff.opcode)
         svalloc_pkg::OP_PLAY: begin
            ua = vhandle_ff[idx_ff];
            uc = best_ff;
         end
         svalloc_pkg::OP_STOP_HANDLE: begin
            ua = vhandle_ff[idx_ff];
            uc = req_ff.voice_handle;
         end
         svalloc_pkg::OP_ADVANCE: begin
            ua = vpos_ff[idx_ff];
            ub = req_ff.advance_bytes;
            uc = vlen_ff[idx_ff];
         end
         default: begin
            ua = 32'd0;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      pick_in    = pick_ff;
      best_in    = best_ff;
      have_in    = have_ff;
      free_in    = free_ff;
      done_in    = done_ff;
      was_in     = was_ff;
      handle_in  = handle_ff;
      counter_in = counter_ff;
      active_in  = active_ff;
      commit_we  = 1'b0;
      pos_we     = 1'b0;
      rsp_valid  = 1'b0;

      case (state_ff)
         svalloc_pkg::ST_IDLE, svalloc_pkg::ST_RESP: begin
            rsp_valid = state_ff == svalloc_pkg::ST_RESP;
            state_in  = svalloc_pkg::ST_IDLE;
            if (accept) begin
               idx_in    = '0;
               pick_in   = '0;
               best_in   = 32'd0;
               have_in   = 1'b0;
               free_in   = 1'b0;
               done_in   = 1'b0;
               was_in    = 1'b0;
               handle_in = 32'd0;
               if ((req.opcode > 3'(svalloc_pkg::OP_ADVANCE)) ||
                   ((req.opcode == 3'(svalloc_pkg::OP_PLAY)) && !sid_ok)) begin
                  state_in = svalloc_pkg::ST_RESP;
               end else begin
                  state_in = svalloc_pkg::ST_SCAN;
               end
            end
         end
         svalloc_pkg::ST_SCAN: begin
            case (req_ff.opcode)
               svalloc_pkg::OP_PLAY: begin
                  if (!free_ff) begin
                     if (!active_ff[idx_ff]) begin
                        pick_in = idx_ff;
                        free_in = 1'b1;
                     end else if (!have_ff || ult) begin
                        pick_in = idx_ff;
                        best_in = vhandle_ff[idx_ff];
                        have_in = 1'b1;
                     end
                  end
               end
               svalloc_pkg::OP_STOP_HANDLE: begin
                  if (!done_ff && ueq) begin
                     was_in            = active_ff[idx_ff];
                     active_in[idx_ff] = 1'b0;
                     done_in           = 1'b1;
                  end
               end
               svalloc_pkg::OP_STOP_ID: begin
                  if (vsound_ff[idx_ff] == req_ff.sound_id) begin
                     was_in            = was_ff | active_ff[idx_ff];
                     active_in[idx_ff] = 1'b0;
                  end
               end
               svalloc_pkg::OP_STOP_ALL: begin
                  active_in[idx_ff] = 1'b0;
               end
               svalloc_pkg::OP_ADVANCE: begin
                  if (active_ff[idx_ff]) begin
                     pos_we = 1'b1;
                     if (!ult) begin
                        active_in[idx_ff] = 1'b0;
                     end
                  end
               end
               default: begin
                  pos_we = 1'b0;
               end
            endcase
            idx_in = idx_ff + 1'b1;
            if (last) begin
               idx_in   = '0;
               state_in = (req_ff.opcode == 3'(svalloc_pkg::OP_PLAY)) ?
                          svalloc_pkg::ST_COMMIT : svalloc_pkg::ST_RESP;
            end
         end
         svalloc_pkg::ST_COMMIT: begin
            commit_we          = 1'b1;
            active_in[pick_ff] = 1'b1;
            handle_in          = counter_ff;
            counter_in         = counter_ff + 32'd1;
            state_in           = svalloc_pkg::ST_RESP;
         end
         default: begin
            state_in = svalloc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= svalloc_pkg::ST_IDLE;
         active_ff  <= '0;
         counter_ff <= 32'd0;
      end else begin
         state_ff   <= state_in;
         active_ff  <= active_in;
         counter_ff <= counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req;
      end
      idx_ff    <= idx_in;
      pick_ff   <= pick_in;
      best_ff   <= best_in;
      have_ff   <= have_in;
      free_ff   <= free_in;
      done_ff   <= done_in;
      was_ff    <= was_in;
      handle_ff <= handle_in;
   end

   // voice table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < svalloc_pkg::VOICES; v++) begin
            vhandle_ff[v] <= 32'd0;
            vsound_ff[v]  <= 8'd0;
            vpos_ff[v]    <= 32'd0;
            vlen_ff[v]    <= 32'd0;
         end
      end else begin
         if (commit_we) begin
            vhandle_ff[pick_ff] <= counter_ff;
            vsound_ff[pick_ff]  <= req_ff.sound_id;
            vpos_ff[pick_ff]    <= 32'd0;
            vlen_ff[pick_ff]    <= req_ff.sound_length;
         end
         if (pos_we) begin
            vpos_ff[idx_ff] <= usum;
         end
      end
   end

   always_comb begin
      rsp.new_handle  = handle_ff;
      rsp.stop_hit    = was_ff;
      rsp.active_mask = 16'(active_ff[svalloc_pkg::MASK_N-1:0]);
   end

endmodule
`default_nettype wire

/* hdl/svalloc_unit.sv */
// shared saturating adder with compare against a third operand
`default_nettype none
module svalloc_unit (
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   input  wire logic [31:0] c,
   output logic      [31:0] sum,
   output logic             lt,
   output logic             eq
);

   logic [32:0] sum_wide;

   always_comb begin
      sum_wide = {1'b0, a} + {1'b0, b};
      sum      = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
      lt       = sum < c;
      eq       = sum == c;
   end

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// self-checking testbench for the voice allocator: directed table, then random requests
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import svalloc_pkg::*;

   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;
   localparam int RANDOM_REQUESTS = 950;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int DRAIN_CYCLES    = 24;

   typedef struct {
      req_type     r;
      int unsigned reps;
      bit          pinned;
      rsp_type     rsp;
   } row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_valid;
   rsp_type rsp;

   // typed response for the directed row now on the bus
   logic    row_pinned;
   rsp_type row_rsp;

   // mirror of the voice table
   logic        vc_on    [VOICES];
   logic [31:0] vc_handle[VOICES];
   logic [7:0]  vc_sound [VOICES];
   logic [31:0] vc_pos   [VOICES];
   logic [31:0] vc_len   [VOICES];
   logic [31:0] handle_counter;

   rsp_type     table_reports_q[$];
   row_type     plan[$];
   int unsigned burst_left;
   int unsigned error_count;
   int unsigned request_count;
   int unsigned directed_count;
   int unsigned play_count;
   int unsigned steal_count;
   int unsigned checked_count;
   int unsigned cycle_count;

   sound_voice_allocator_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type voice_table_step(req_type r);
      rsp_type o;
      int      slot;
      logic    hit;
      o    = '0;
      slot = -1;
      hit  = 1'b0;
      case (r.opcode)
         OP_PLAY: begin
            if (r.sound_id < SOUND_IDS) begin
               for (int v = 0; v < VOICES; v++)
                  if (slot < 0 && !vc_on[v]) slot = v;
               if (slot < 0) begin
                  slot = 0;
                  for (int v = 1; v < VOICES; v++)
                     if (vc_handle[v] < vc_handle[slot]) slot = v;
                  steal_count++;
               end
               play_count++;
               o.new_handle    = handle_counter;
               handle_counter  = handle_counter + 32'd1;
               vc_handle[slot] = o.new_handle;
               vc_sound[slot]  = r.sound_id;
               vc_on[slot]     = 1'b1;
               vc_len[slot]    = r.sound_length;
               vc_pos[slot]    = '0;
            end
         end
         OP_STOP_HANDLE: begin
            for (int v = 0; v < VOICES; v++) begin
               if (!hit && vc_handle[v] == r.voice_handle) begin
                  hit        = 1'b1;
                  o.stop_hit = vc_on[v];
                  vc_on[v]   = 1'b0;
               end
            end
         end
         OP_STOP_ID: begin
            for (int v = 0; v < VOICES; v++) begin
               if (vc_sound[v] == r.sound_id) begin
                  if (vc_on[v]) o.stop_hit = 1'b1;
                  vc_on[v] = 1'b0;
               end
            end
         end
         OP_STOP_ALL: begin
            for (int v = 0; v < VOICES; v++) vc_on[v] = 1'b0;
         end
         OP_ADVANCE: begin
            for (int v = 0; v < VOICES; v++) begin
               if (vc_on[v]) begin
                  if (vc_pos[v] > 32'hFFFF_FFFF - r.advance_bytes) vc_pos[v] = '1;
                  else vc_pos[v] = vc_pos[v] + r.advance_bytes;
                  if (vc_pos[v] >= vc_len[v]) vc_on[v] = 1'b0;
               end
            end
         end
         default: ;
      endcase
      for (int v = 0; v < MASK_N; v++) o.active_mask[v] = vc_on[v];
      return o;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type step_rsp;
      if (!reset) begin
         if (rsp_valid) begin
            if (table_reports_q.size() == 0) begin
               $display("%0t: response with none pending, expected none, actual %h",
                        $time, rsp);
               error_count++;
            end else begin
               want = table_reports_q.pop_front();
               compare_field("new_handle", want.new_handle, rsp.new_handle);
               compare_field("stop_hit", 32'(want.stop_hit), 32'(rsp.stop_hit));
               compare_field("active_mask", 32'(want.active_mask), 32'(rsp.active_mask));
               checked_count++;
            end
         end
         if (start && !busy) begin
            step_rsp = voice_table_step(req);
            table_reports_q.push_back(row_pinned ? row_rsp : step_rsp);
            request_count++;
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      cycle_count = 0;
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout with %0d responses pending", $time, table_reports_q.size());
      $display("== FAIL ==");
      $finish;
   end

   function automatic void add_row(logic [2:0] op, logic [7:0] sid, logic [31:0] len,
                                   logic [31:0] hnd, logic [31:0] adv, int unsigned reps,
                                   bit pinned, rsp_type prsp);
      row_type row;
      row.r      = '{op, sid, len, hnd, adv};
      row.reps   = reps;
      row.pinned = pinned;
      row.rsp    = prsp;
      plan.push_back(row);
   endfunction

   function automatic req_type roll_request();
      req_type     r;
      int unsigned pick;
      r.sound_id      = 8'($urandom);
      r.sound_length  = $urandom;
      r.voice_handle  = $urandom;
      r.advance_bytes = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 40) r.opcode = OP_PLAY;
      else if (pick < 55) r.opcode = OP_STOP_HANDLE;
      else if (pick < 68) r.opcode = OP_STOP_ID;
      else if (pick < 71) r.opcode = OP_STOP_ALL;
      else if (pick < 95) r.opcode = OP_ADVANCE;
      else r.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      if ($urandom_range(0, 3) != 0) r.sound_id = 8'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
         0: r.sound_length = $urandom_range(0, 64);
         1: r.sound_length = $urandom_range(65, 4096);
         2: r.sound_length = '1;
         default: ;
      endcase
      if ($urandom_range(0, 4) != 0)
         r.voice_handle = handle_counter - 32'($urandom_range(1, 24));
      case ($urandom_range(0, 7))
         0: r.advance_bytes = '0;
         1: r.advance_bytes = '1;
         2: ;
         default: r.advance_bytes = $urandom_range(1, 24);
      endcase
      return r;
   endfunction

   task automatic pace();
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 24);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
   endtask

   task automatic issue(req_type r, bit pinned, rsp_type prsp);
      start      <= 1'b1;
      req        <= r;
      row_pinned <= pinned;
      row_rsp    <= prsp;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req            = '0;
      row_pinned     = 1'b0;
      row_rsp        = '0;
      handle_counter = '0;
      burst_left     = 0;
      error_count    = 0;
      request_count  = 0;
      directed_count = 0;
      play_count     = 0;
      steal_count    = 0;
      checked_count  = 0;
      for (int v = 0; v < VOICES; v++) begin
         vc_on[v]     = 1'b0;
         vc_handle[v] = '0;
         vc_sound[v]  = '0;
         vc_pos[v]    = '0;
         vc_len[v]    = '0;
      end

      // empty table: every stop matches only inactive voices
      add_row(OP_ADVANCE,     8'h00, 32'h0, 32'h0, 32'h0, 1, 1, '0);
      add_row(OP_STOP_HANDLE, 8'h00, 32'h0, 32'h0, 32'h0, 1, 1, '0);
      add_row(OP_STOP_ID,     8'h00, 32'h0, 32'h0, 32'h0, 1, 1, '0);
      add_row(OP_STOP_ALL,    8'h00, 32'h0, 32'h0, 32'h0, 1, 1, '0);
      add_row(OP_UNUSED_LO,   8'hFF, '1, '1, '1,          1, 1, '0);
      add_row(OP_UNUSED_HI,   8'h00, 32'h0, 32'h0, 32'h0, 1, 1, '0);
      // zero length dies on the next advance even with zero bytes
      add_row(OP_PLAY,        8'hFF, 32'h0, 32'h0, 32'h0, 1, 1, '{32'd0, 1'b0, 16'h0001});
      add_row(OP_ADVANCE,     8'h00, 32'h0, 32'h0, 32'h0, 1, 1, '0);
      // saturating position
      add_row(OP_PLAY,        8'h00, '1, 32'h0, 32'h0,    1, 1, '{32'd1, 1'b0, 16'h0001});
      add_row(OP_ADVANCE,     8'h00, 32'h0, 32'h0, '1,    1, 1, '0);
      add_row(OP_PLAY,        8'h5A, '1, 32'h0, 32'h0,    1, 1, '{32'd2, 1'b0, 16'h0001});
      add_row(OP_ADVANCE,     8'h00, 32'h0, 32'h0, 32'h8000_0000, 1, 0, '0);
      add_row(OP_ADVANCE,     8'h00, 32'h0, 32'h0, 32'h8000_0001, 1, 0, '0);
      // stop by handle hitting an inactive voice, then an active one
      add_row(OP_STOP_HANDLE, 8'h00, 32'h0, 32'd2, 32'h0, 1, 1, '0);
      add_row(OP_PLAY,        8'h5A, 32'd10, 32'h0, 32'h0, 1, 1, '{32'd3, 1'b0, 16'h0001});
      add_row(OP_STOP_HANDLE, 8'h00, 32'h0, 32'd3, 32'h0, 1, 1, '{32'd0, 1'b1, 16'h0000});
      // fill every voice, then steal the oldest
      add_row(OP_PLAY,        8'h09, '1, 32'h0, 32'h0,    VOICES, 0, '0);
      add_row(OP_PLAY,        8'hA5, 32'd5, 32'h0, 32'h0, 1, 0, '0);
      add_row(OP_STOP_ID,     8'h09, 32'h0, 32'h0, 32'h0, 1, 0, '0);
      add_row(OP_STOP_HANDLE, 8'h00, 32'h0, '1, 32'h0,    1, 0, '0);
      add_row(OP_ADVANCE,     8'h00, 32'h0, 32'h0, 32'd5, 1, 0, '0);
      add_row(OP_STOP_ID,     8'h09, 32'h0, 32'h0, 32'h0, 1, 0, '0);
      add_row(OP_STOP_ALL,    8'h00, 32'h0, 32'h0, 32'h0, 1, 0, '0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         repeat (plan[i].reps) begin
            pace();
            issue(plan[i].r, plan[i].pinned, plan[i].rsp);
            directed_count++;
         end
      end
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         pace();
         issue(roll_request(), 1'b0, '0);
      end
      start <= 1'b0;

      while (table_reports_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests (%0d from the directed table), %0d plays, %0d steals",
               request_count, directed_count, play_count, steal_count);
      $display("%0d responses checked, %0d mismatches", checked_count, error_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
